// ===== rtl/vsd_pkg.sv =====
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared types and constants for the vector similarity / distance unit.
// ----------------------------------------------------------------------------
package vsd_pkg;

  localparam int ELEM_W  = 16;
  localparam int ACC_W   = 44;
  localparam int MAX_DIM = 4096;
  localparam int CNT_W   = 13;
  localparam int ROOT_W  = 31;
  localparam int OUT_W   = 23;

  // metric select codes
  localparam logic MODE_COSINE    = 1'b0;
  localparam logic MODE_EUCLIDEAN = 1'b1;

  // register index of metric_mode
  localparam logic REG_METRIC_MODE = 1'b0;

  // closed vector handed from the accumulator to the result engine
  typedef struct packed {
    logic             mode;
    logic             too_long;
    logic [ACC_W-1:0] dot;
    logic [ACC_W-1:0] norm_a;
    logic [ACC_W-1:0] norm_b;
  } job_t;

endpackage

// ===== rtl/vsd_front.sv =====
// ----------------------------------------------------------------------------
// vsd_front
// Accumulates element pairs and hands each closed vector to the job queue.
// ----------------------------------------------------------------------------
module vsd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        mode,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,   // [15:0] elem_a, [31:16] elem_b
  input  logic                        s_tlast,   // last_pair
  input  logic                        q_full,
  output logic                        push,
  output vsd_pkg::job_t               push_job
);
  import vsd_pkg::*;

  logic [ACC_W-1:0] dot_sum, norm_a_sum, norm_b_sum;
  logic [ACC_W-1:0] dot_next, norm_a_next, norm_b_next;
  logic [CNT_W-1:0] pair_count;
  logic             overflow_seen, overflow_next;
  logic             accept, take;

  logic signed [ELEM_W-1:0]   a, b;
  logic signed [2*ELEM_W-1:0] p_ab, p_aa, p_bb;
  logic signed [ELEM_W:0]     d;
  logic signed [2*ELEM_W+1:0] p_dd;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign a        = s_tdata[15:0];
  assign b        = s_tdata[31:16];

  // products for this pair
  assign p_ab = a * b;
  assign p_aa = a * a;
  assign p_bb = b * b;
  assign d    = {a[ELEM_W-1], a} - {b[ELEM_W-1], b};
  assign p_dd = d * d;

  assign take = (pair_count < CNT_W'(MAX_DIM));

  // accumulator update
  always_comb begin
    dot_next      = dot_sum;
    norm_a_next   = norm_a_sum;
    norm_b_next   = norm_b_sum;
    overflow_next = overflow_seen;
    if (!take) begin
      overflow_next = 1'b1;
    end else if (mode == MODE_COSINE) begin
      dot_next    = dot_sum + {{(ACC_W-2*ELEM_W){p_ab[2*ELEM_W-1]}}, p_ab};
      norm_a_next = norm_a_sum + {{(ACC_W-2*ELEM_W){p_aa[2*ELEM_W-1]}}, p_aa};
      norm_b_next = norm_b_sum + {{(ACC_W-2*ELEM_W){p_bb[2*ELEM_W-1]}}, p_bb};
    end else begin
      norm_b_next = norm_b_sum + {{(ACC_W-2*ELEM_W-2){p_dd[2*ELEM_W+1]}}, p_dd};
    end
  end

  assign push = accept && s_tlast;

  always_comb begin
    push_job.mode     = mode;
    push_job.too_long = overflow_next;
    push_job.dot      = dot_next;
    push_job.norm_a   = norm_a_next;
    push_job.norm_b   = norm_b_next;
  end

  // state registers, cleared after each closed vector
  always_ff @(posedge clk) begin
    if (rst || push) begin
      dot_sum       <= '0;
      norm_a_sum    <= '0;
      norm_b_sum    <= '0;
      pair_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      dot_sum       <= dot_next;
      norm_a_sum    <= norm_a_next;
      norm_b_sum    <= norm_b_next;
      overflow_seen <= overflow_next;
      if (take) pair_count <= pair_count + 1'b1;
    end
  end

endmodule

// ===== rtl/vsd_queue.sv =====
// ----------------------------------------------------------------------------
// vsd_queue
// Two-entry job queue between the accumulator and the result engine.
// ----------------------------------------------------------------------------
module vsd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vsd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output vsd_pkg::job_t head
);
  import vsd_pkg::*;

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/vsd_back.sv =====
// ----------------------------------------------------------------------------
// vsd_back
// Result engine: bit-serial square roots, one multiply, serial divide, and
// the output register.
// ----------------------------------------------------------------------------
module vsd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  vsd_pkg::job_t q_head,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [23:0]   m_tdata,   // [22:0] metric_value
  output logic [1:0]    m_tuser    // [0] zero_norm, [1] too_long
);
  import vsd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQA  = 8'b0000_0010,
    S_SQB  = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_CHK  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_SIGN = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state;

  logic                  mode, neg;
  logic [ACC_W-1:0]      mag, norm_b;
  logic [2*ROOT_W-1:0]   sq_x;
  logic [ROOT_W+2:0]     sq_rem;
  logic [ROOT_W-1:0]     sq_root, root_a, root_b;
  logic [4:0]            sq_cnt;
  logic [2*ROOT_W-1:0]   den, rem_d;
  logic [15:0]           qmag;
  logic [3:0]            div_cnt;
  logic [OUT_W-1:0]      res_value;
  logic                  res_zero, res_long;
  logic                  out_load;

  // one square-root digit per cycle
  logic [ROOT_W+2:0] rem_sh, trial;
  logic              sq_ge;
  logic [ROOT_W-1:0] root_next;
  logic [ROOT_W+2:0] rem_next;

  assign rem_sh    = {sq_rem[ROOT_W:0], sq_x[2*ROOT_W-1 -: 2]};
  assign trial     = {1'b0, sq_root, 2'b01};
  assign sq_ge     = (rem_sh >= trial);
  assign rem_next  = sq_ge ? (rem_sh - trial) : rem_sh;
  assign root_next = {sq_root[ROOT_W-2:0], sq_ge};

  // one quotient bit per cycle
  logic [2*ROOT_W:0] div_sh;
  logic              div_ge;
  assign div_sh = {rem_d, 1'b0};
  assign div_ge = (div_sh >= {1'b0, den});

  logic [ACC_W-1:0] head_mag;
  assign head_mag = q_head.dot[ACC_W-1] ? (~q_head.dot + 1'b1) : q_head.dot;

  assign pop = (state == S_IDLE) && q_valid;

  // output register loads when the finished item can move out
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            mode     <= q_head.mode;
            res_long <= q_head.too_long;
            res_zero <= 1'b0;
            neg      <= q_head.dot[ACC_W-1];
            mag      <= head_mag;
            norm_b   <= q_head.norm_b;
            sq_rem   <= '0;
            sq_root  <= '0;
            sq_cnt   <= '0;
            if (q_head.mode == MODE_EUCLIDEAN) begin
              sq_x  <= {{(2*ROOT_W-ACC_W){1'b0}}, q_head.norm_b};
              state <= S_SQB;
            end else if (q_head.norm_a == '0 || q_head.norm_b == '0) begin
              res_value <= '0;
              res_zero  <= 1'b1;
              state     <= S_DONE;
            end else begin
              sq_x  <= {q_head.norm_a, 18'b0};
              state <= S_SQA;
            end
          end
        end
        S_SQA: begin
          sq_x    <= {sq_x[2*ROOT_W-3:0], 2'b00};
          sq_rem  <= rem_next;
          sq_root <= root_next;
          sq_cnt  <= sq_cnt + 1'b1;
          if (sq_cnt == 5'(ROOT_W-1)) begin
            root_a  <= root_next;
            sq_x    <= {norm_b, 18'b0};
            sq_rem  <= '0;
            sq_root <= '0;
            sq_cnt  <= '0;
            state   <= S_SQB;
          end
        end
        S_SQB: begin
          sq_x    <= {sq_x[2*ROOT_W-3:0], 2'b00};
          sq_rem  <= rem_next;
          sq_root <= root_next;
          sq_cnt  <= sq_cnt + 1'b1;
          if (sq_cnt == 5'(ROOT_W-1)) begin
            root_b <= root_next;
            if (mode == MODE_EUCLIDEAN) begin
              res_value <= {1'b0, root_next[OUT_W-2:0]};
              state     <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          den   <= root_a * root_b;
          state <= S_CHK;
        end
        S_CHK: begin
          // quotient of 2^15 or more saturates
          if ({mag, 18'b0} >= den) begin
            qmag  <= 16'h8000;
            state <= S_SIGN;
          end else begin
            rem_d   <= {mag, 18'b0};
            qmag    <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem_d   <= div_ge ? (2*ROOT_W)'(div_sh - {1'b0, den}) : div_sh[2*ROOT_W-1:0];
          qmag    <= {qmag[14:0], div_ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 4'd14) state <= S_SIGN;
        end
        S_SIGN: begin
          if (neg)
            res_value <= OUT_W'(-$signed({1'b0, qmag}));
          else if (qmag[15])
            res_value <= OUT_W'(32767);
          else
            res_value <= {{(OUT_W-16){1'b0}}, qmag};
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            m_tdata <= {1'b0, res_value};
            m_tuser <= {res_long, res_zero};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/vector_similarity_distance_unit.sv =====
// ----------------------------------------------------------------------------
// vector_similarity_distance_unit
// Cosine similarity or euclidean distance of two streamed Q1.15 vectors.
// ----------------------------------------------------------------------------
// Accepts one element pair per cycle while the job queue has room; two closed
// vectors may wait while the result engine works and the next one accumulates.
// In cosine mode the engine runs two 31-step roots, multiply, check, 15-step divide and
// sign; saturation skips the divide, a zero norm goes straight to the output, and
// euclidean mode runs one root; the engine takes a new vector only when idle.
// Synchronous active-high reset clears accumulators, queue, output and mode.
module vector_similarity_distance_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // element pairs
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] elem_a, [31:16] elem_b
  input  logic        s_tlast,   // last_pair
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [22:0] metric_value, [23] zero fill
  output logic [1:0]  m_tuser    // [0] zero_norm, [1] too_long
);
  import vsd_pkg::*;

  logic  metric_mode;
  logic  q_full, q_valid, push, pop;
  job_t  push_job, q_head;

  // register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= MODE_COSINE;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_METRIC_MODE) begin
      metric_mode <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == REG_METRIC_MODE) ? {31'b0, metric_mode} : 32'b0;

  vsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .mode     (metric_mode),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  vsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  vsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== dv/vector_similarity_distance_unit_test.sv =====
// ----------------------------------------------------------------------------
// vector_similarity_distance_unit_test
// Self-checking bench for the cosine / euclidean vector unit: element pairs
// stream in, a local model predicts each closed vector's metric and flags,
// and every result item is compared in order against that prediction.
// ----------------------------------------------------------------------------
module vector_similarity_distance_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vsd_pkg::*;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               last;
  } pair_t;

  typedef struct {
    logic [22:0] metric;
    logic        zero_norm;
    logic        too_long;
  } metric_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] elem_a, [31:16] elem_b
  logic        s_tlast = 1'b0; // last_pair
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [22:0] metric_value, [23] zero fill
  logic [1:0]  m_tuser;        // [0] zero_norm, [1] too_long

  vector_similarity_distance_unit u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  pair_t   pair_fifo[$];
  metric_t metric_fifo[$];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      send_hold = 1'b0;
  int      mismatches = 0;
  int      vectors_seen = 0;
  int      pairs_sent = 0;

  // model copy of the datapath state
  logic            mdl_mode = MODE_COSINE;
  logic [43:0]     mdl_dot, mdl_na, mdl_nb;
  int              mdl_count;
  logic            mdl_over;

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic clear_sums();
    mdl_dot = '0; mdl_na = '0; mdl_nb = '0; mdl_count = 0; mdl_over = 1'b0;
  endtask

  // accumulate one pair; on the last pair queue the expected metric
  task automatic predict_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                              input logic last);
    longint signed   ea, eb, d, val;
    longint unsigned sa, sb, den, mag, q, r;
    logic            neg;
    metric_t         exp_item;
    ea = a; eb = b; val = 0;
    exp_item.zero_norm = 1'b0;
    if (mdl_count >= MAX_DIM) begin
      mdl_over = 1'b1;
    end else begin
      if (mdl_mode == MODE_COSINE) begin
        mdl_dot = mdl_dot + 44'(ea * eb);
        mdl_na  = mdl_na + 44'(ea * ea);
        mdl_nb  = mdl_nb + 44'(eb * eb);
      end else begin
        d = ea - eb;
        mdl_nb = mdl_nb + 44'(d * d);
      end
      mdl_count++;
    end
    if (!last) return;
    if (mdl_mode == MODE_COSINE) begin
      if (mdl_na == 0 || mdl_nb == 0) begin
        exp_item.zero_norm = 1'b1;
      end else begin
        sa = floor_sqrt({20'd0, mdl_na} << 18);
        sb = floor_sqrt({20'd0, mdl_nb} << 18);
        den = sa * sb;
        neg = mdl_dot[43];
        mag = neg ? {20'd0, 44'(-mdl_dot)} : {20'd0, mdl_dot};
        q = mag / den;
        r = mag % den;
        for (int i = 0; i < 33; i++) begin
          r = r << 1;
          q = (q << 1) & ((64'd1 << 40) - 1);
          if (r >= den) begin
            r = r - den;
            q = q | 1;
          end
          if (q > 32768) q = 32768;
        end
        if (neg) val = -longint'(q);
        else val = (q > 32767) ? 32767 : longint'(q);
      end
    end else begin
      val = longint'(floor_sqrt({20'd0, mdl_nb}));
    end
    exp_item.metric = val[22:0];
    exp_item.too_long = mdl_over;
    metric_fifo = {metric_fifo, exp_item};
    clear_sums();
  endtask

  // pair driver and result ready
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!s_tvalid || s_tready) begin
        if (pair_fifo.size() > 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {pair_fifo[0].b, pair_fifo[0].a};
          s_tlast  <= pair_fifo[0].last;
          void'(pair_fifo.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // accepted pairs feed the model, accepted results are checked
  always @(posedge clk) begin
    metric_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_pair(s_tdata[15:0], s_tdata[31:16], s_tlast);
        pairs_sent++;
      end
      if (m_tvalid && m_tready) begin
        got.metric = m_tdata[22:0];
        got.zero_norm = m_tuser[0];
        got.too_long = m_tuser[1];
        vectors_seen++;
        if (metric_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: metric %0h", got.metric);
        end else begin
          if (got.metric !== metric_fifo[0].metric || got.zero_norm !== metric_fifo[0].zero_norm
              || got.too_long !== metric_fifo[0].too_long || m_tdata[23] !== 1'b0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected metric %0h zn %b tl %b, got %0h zn %b tl %b",
                       metric_fifo[0].metric, metric_fifo[0].zero_norm,
                       metric_fifo[0].too_long, got.metric, got.zero_norm, got.too_long);
          end
          void'(metric_fifo.pop_front());
        end
      end
    end
  end

  task automatic write_mode(input logic value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * REG_METRIC_MODE); pwdata <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mdl_mode = value;
  endtask

  task automatic push(input int a, input int b, input logic last);
    pair_t p;
    p.a = 16'(a); p.b = 16'(b); p.last = last;
    pair_fifo = {pair_fifo, p};
  endtask

  // wait until every result is in, then let the result engine settle
  task automatic drain();
    while (pair_fifo.size() != 0 || s_tvalid || metric_fifo.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic int rand_elem();
    case ($urandom_range(5))
      0: return 32767;
      1: return -32768;
      2: return 0;
      3: return $signed(16'($urandom_range(255))) - 128;
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  // vector of random length with random content, sometimes degenerate
  task automatic push_random_vector();
    int len, kind;
    len = $urandom_range(8, 1);
    kind = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      int a, b;
      a = rand_elem();
      b = rand_elem();
      if (kind == 0) a = 0;
      if (kind == 1) b = a;
      if (kind == 2) b = -a;
      push(a, b, i == len - 1);
    end
  endtask

  initial begin
    clear_sums();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_mode(MODE_COSINE);

    // directed cosine: extremes, saturation, zero norms, mixed signs
    push(32767, 32767, 1);
    push(-32768, -32768, 1);
    push(32767, -32768, 1);
    push(1, -1, 1);
    push(0, 0, 1);
    push(5, 0, 0); push(0, 0, 1);
    push(0, 7, 1);
    push(-32768, 32767, 0); push(1, 2, 0); push(3, -4, 1);
    // sender holds its next pairs until every expected result is back
    while (pair_fifo.size() != 0 || s_tvalid) @(posedge clk);
    send_hold = 1'b1;
    // mode changes partway through a vector
    push(100, 200, 0); push(300, -5, 0);
    while (metric_fifo.size() != 0) @(posedge clk);
    send_hold = 1'b0;
    drain();
    write_mode(MODE_EUCLIDEAN);
    push(7, -9, 0); push(32767, -32768, 1);
    push(-32768, 32767, 1);
    push(0, 0, 1);
    push(-1, 1, 0); push(12, 12, 1);
    push(50, 60, 0);
    drain();
    write_mode(MODE_COSINE);
    push(40, -30, 1);
    drain();

    // random vectors under three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 76 : 0;
      recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 26 : 0;
      for (int sub = 0; sub < 2; sub++) begin
        write_mode(logic'($urandom_range(1)));
        for (int n = 0; n < 60 && pair_fifo.size() < 300; n = n + 0) begin
          push_random_vector();
          n = pair_fifo.size();
        end
        drain();
      end
    end

    $display("covered %0d pairs and %0d result items in both metric modes,", pairs_sent,
             vectors_seen);
    $display("including saturation, zero norms, mode switches and a paused sender");
    if (mismatches == 0 && metric_fifo.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
